/* rtl/core/tshp_pkg.sv */
// Package with shared types and constants for the tar stream header parser.
`timescale 1ns / 1ps
package tshp_pkg;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  entry_type;
        logic [31:0] file_size;
        logic [11:0] file_mode;
        logic [23:0] owner_id;
        logic [23:0] group_id;
        logic [31:0] modify_time;
        logic [15:0] device_number;
        logic [7:0]  data_out;
        logic        data_last;
        logic [2:0]  error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DATA   = 3'd1,
        PH_SKIP   = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_OCTAL = 3'd1;
    localparam logic [2:0] ERR_CSUM  = 3'd2;
    localparam logic [2:0] ERR_TYPE  = 3'd3;
    localparam logic [2:0] ERR_EARLY = 3'd4;

    localparam logic [8:0] BLK_LAST = 9'd511;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

endpackage

/* rtl/core/tshp_front.sv */
// Front part: byte-serial header decode, data pass-through and block skipping.
`timescale 1ns / 1ps
module tshp_front
    import tshp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_item_t  in_item,
    output logic      res_valid,
    output out_item_t res_item
);

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg;
    logic [31:0] rem_reg, rem_next;
    logic [16:0] csum_reg, csum_next;
    logic [17:0] stored_reg, stored_next;
    logic [31:0] size_reg, size_next, mtime_reg, mtime_next;
    logic [23:0] mode_reg, mode_next, uid_reg, uid_next, gid_reg, gid_next;
    logic [23:0] major_reg, major_next, minor_reg, minor_next;
    logic        term_reg, term_next, zfb_reg, zfb_next;
    logic [2:0]  fault_reg, fault_next;
    logic [7:0]  type_reg, type_next;

    logic [7:0]  b;
    logic [8:0]  p;
    logic        is_oct, is_stop, in_field, field_start;
    logic [2:0]  dig;
    logic [2:0]  fbit;
    logic [31:0] rem_dec;
    logic [2:0]  kind;
    logic        kind_ok;

    always_comb
    begin
        b = in_item.stream_byte;
        p = pos_reg;
        is_oct = (b >= 8'h30) && (b <= 8'h37);
        is_stop = (b == 8'h00) || (b == 8'h20);
        dig = b[2:0];
        rem_dec = rem_reg - 32'd1;
        field_start = (p == 9'd100) || (p == 9'd108) || (p == 9'd116) || (p == 9'd124)
            || (p == 9'd136) || (p == 9'd148) || (p == 9'd329) || (p == 9'd337);
        in_field = ((p >= 9'd100) && (p <= 9'd153)) || ((p >= 9'd329) && (p <= 9'd344));
        if ((p >= 9'd124) && (p <= 9'd135))
            fbit = 3'b010;
        else if ((p >= 9'd148) && (p <= 9'd153))
            fbit = 3'b001;
        else
            fbit = 3'b100;
        kind_ok = 1'b1;
        kind = 3'd0;
        unique case (type_reg)
            8'h00, 8'h30: kind = 3'd0;
            8'h35:        kind = 3'd1;
            8'h32:        kind = 3'd2;
            8'h31:        kind = 3'd3;
            8'h33:        kind = 3'd4;
            8'h34:        kind = 3'd5;
            8'h36:        kind = 3'd6;
            default:      kind_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        rem_next = rem_reg;
        csum_next = csum_reg;
        stored_next = stored_reg;
        size_next = size_reg;
        mtime_next = mtime_reg;
        mode_next = mode_reg;
        uid_next = uid_reg;
        gid_next = gid_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        term_next = term_reg;
        zfb_next = zfb_reg;
        fault_next = fault_reg;
        type_next = type_reg;
        res_valid = 1'b0;
        res_item = '0;
        if (in_valid && (phase_reg == PH_HEADER || phase_reg == PH_DATA
                || phase_reg == PH_SKIP))
        begin
            if (in_item.stream_end)
            begin
                res_valid = 1'b1;
                res_item.result_kind = KIND_ERROR;
                res_item.error_code = ERR_EARLY;
                phase_next = PH_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (p == 9'd0)
                        begin
                            csum_next = '0;
                            stored_next = '0;
                            size_next = '0;
                            mode_next = '0;
                            uid_next = '0;
                            gid_next = '0;
                            mtime_next = '0;
                            major_next = '0;
                            minor_next = '0;
                            fault_next = '0;
                            type_next = '0;
                            zfb_next = (b == 8'h00);
                        end
                        csum_next = ((p == 9'd0) ? 17'd0 : csum_reg)
                            + (((p >= 9'd148) && (p <= 9'd155)) ? 17'h20 : {9'd0, b});
                        if (field_start)
                            term_next = 1'b0;
                        if (in_field && (field_start || !term_reg))
                        begin
                            if (is_oct)
                            begin
                                if (p >= 9'd337)
                                    minor_next = {minor_reg[20:0], dig};
                                else if (p >= 9'd329)
                                    major_next = {major_reg[20:0], dig};
                                else if (p >= 9'd148)
                                    stored_next = {stored_reg[14:0], dig};
                                else if (p >= 9'd136)
                                    mtime_next = {mtime_reg[28:0], dig};
                                else if (p >= 9'd124)
                                    size_next = {size_reg[28:0], dig};
                                else if (p >= 9'd116)
                                    gid_next = {gid_reg[20:0], dig};
                                else if (p >= 9'd108)
                                    uid_next = {uid_reg[20:0], dig};
                                else
                                    mode_next = {mode_reg[20:0], dig};
                            end
                            else
                            begin
                                term_next = 1'b1;
                                if (!is_stop)
                                    fault_next = fault_reg | fbit;
                            end
                        end
                        if (p == 9'd156)
                            type_next = b;
                        if (p == BLK_LAST)
                        begin
                            priority if (zfb_reg)
                            begin
                                res_valid = 1'b1;
                                res_item.result_kind = KIND_END;
                                phase_next = PH_DONE;
                            end
                            else if (fault_reg[0] || ({1'b0, csum_next} != stored_reg)
                                || fault_reg[1])
                            begin
                                res_valid = 1'b1;
                                res_item.result_kind = KIND_ERROR;
                                res_item.error_code = (!fault_reg[0]
                                    && ({1'b0, csum_next} != stored_reg))
                                    ? ERR_CSUM : ERR_OCTAL;
                                phase_next = PH_ERROR;
                            end
                            else if (type_reg == 8'h4B || type_reg == 8'h4C)
                            begin
                                rem_next = size_reg;
                                phase_next = (size_reg != 32'd0) ? PH_SKIP : PH_HEADER;
                            end
                            else if (fault_reg[2] || !kind_ok)
                            begin
                                res_valid = 1'b1;
                                res_item.result_kind = KIND_ERROR;
                                res_item.error_code = fault_reg[2] ? ERR_OCTAL : ERR_TYPE;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                                res_item.result_kind = KIND_HEADER;
                                res_item.entry_type = kind;
                                res_item.file_size = size_reg;
                                res_item.file_mode = mode_reg[11:0];
                                res_item.owner_id = uid_reg;
                                res_item.group_id = gid_reg;
                                res_item.modify_time = mtime_reg;
                                res_item.device_number = {major_reg[7:0], minor_reg[7:0]};
                                rem_next = size_reg;
                                phase_next = (kind == 3'd0 && size_reg != 32'd0)
                                    ? PH_DATA : PH_HEADER;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        rem_next = rem_dec;
                        res_valid = 1'b1;
                        res_item.result_kind = KIND_DATA;
                        res_item.data_out = b;
                        res_item.data_last = (rem_dec == 32'd0);
                        if (rem_dec == 32'd0)
                            phase_next = (p == BLK_LAST) ? PH_HEADER : PH_SKIP;
                    end
                    default:
                    begin
                        if (rem_reg != 32'd0)
                            rem_next = rem_dec;
                        if (p == BLK_LAST && rem_next == 32'd0)
                            phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg <= '0;
            rem_reg <= '0;
            csum_reg <= '0;
            stored_reg <= '0;
            size_reg <= '0;
            mtime_reg <= '0;
            mode_reg <= '0;
            uid_reg <= '0;
            gid_reg <= '0;
            major_reg <= '0;
            minor_reg <= '0;
            term_reg <= 1'b0;
            zfb_reg <= 1'b0;
            fault_reg <= '0;
            type_reg <= '0;
        end
        else
        begin
            if (in_valid && !in_item.stream_end && (phase_reg == PH_HEADER
                    || phase_reg == PH_DATA || phase_reg == PH_SKIP))
                pos_reg <= pos_reg + 9'd1;
            phase_reg <= phase_next;
            rem_reg <= rem_next;
            csum_reg <= csum_next;
            stored_reg <= stored_next;
            size_reg <= size_next;
            mtime_reg <= mtime_next;
            mode_reg <= mode_next;
            uid_reg <= uid_next;
            gid_reg <= gid_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
            term_reg <= term_next;
            zfb_reg <= zfb_next;
            fault_reg <= fault_next;
            type_reg <= type_next;
        end
    end

endmodule

/* rtl/core/tshp_queue.sv */
// Back part: result queue between the decoder and the result port.
`timescale 1ns / 1ps
module tshp_queue
    import tshp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  out_item_t wr_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t rd_item
);

    out_item_t      mem [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_pop, do_push;

    assign full = (count_reg >= (QAW + 1)'(QDEPTH - 1));
    assign empty = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign do_push = wr_en;
    assign rd_item = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
        end
    end

endmodule

/* rtl/core/tar_stream_header_parser_top.sv */
// Top level of the tar stream header parser.
// A result becomes visible in the cycle after the request that causes it.
// Throughput: one byte per cycle while full is low; full rises when three results wait unread.
// Reset: asynchronous, active low; parsing restarts at a header block.
// Header results are produced on the last byte of a 512-byte header block.
`timescale 1ns / 1ps
module tar_stream_header_parser_top
    import tshp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic      res_valid;
    out_item_t res_item;

    tshp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push && !full), .in_item(in_item),
        .res_valid(res_valid), .res_item(res_item)
    );

    tshp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_item(res_item),
        .full(full), .empty(empty), .pop(pop), .rd_item(out_item)
    );

endmodule

/* rtl/core/tshp_checker.sv */
// Port-level checker for the tar stream header parser, bound to the top level.
`timescale 1ns / 1ps
module tshp_checker
    import tshp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(empty) && empty == 1'b0) |-> $past(push && !full))
        else $error("result without request");

    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.result_kind != KIND_DATA) |-> !out_item.data_last)
        else $error("last marker on non-data result");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.result_kind == KIND_ERROR) |-> (out_item.error_code != 3'd0))
        else $error("error result without code");

endmodule

bind tar_stream_header_parser_top tshp_checker u_checker (.*);

/* sim/tar_stream_header_parser_top_tb.sv */
// Self-checking testbench for the tar stream header parser, driven by generated archives.
`timescale 1ns / 1ps
module tar_stream_header_parser_top_tb;
    import tshp_pkg::*;

    localparam logic [2:0] ET_REG   = 3'd0;
    localparam logic [2:0] ET_DIR   = 3'd1;
    localparam logic [2:0] ET_SYM   = 3'd2;
    localparam logic [2:0] ET_HARD  = 3'd3;
    localparam logic [2:0] ET_CHR   = 3'd4;
    localparam logic [2:0] ET_BLK   = 3'd5;
    localparam logic [2:0] ET_FIFO  = 3'd6;

    localparam logic [2:0] FAULT_CSUM  = 3'd1;
    localparam logic [2:0] FAULT_SIZE  = 3'd2;
    localparam logic [2:0] FAULT_OTHER = 3'd4;

    localparam int FL_NONE        = 0;
    localparam int FL_CSUM_DIGIT  = 1;
    localparam int FL_CSUM_WRONG  = 2;
    localparam int FL_SIZE_DIGIT  = 3;
    localparam int FL_OTHER_DIGIT = 4;

    localparam logic [7:0] TY_NUL  = 8'h00;
    localparam logic [7:0] TY_REG  = 8'h30;
    localparam logic [7:0] TY_HARD = 8'h31;
    localparam logic [7:0] TY_SYM  = 8'h32;
    localparam logic [7:0] TY_CHR  = 8'h33;
    localparam logic [7:0] TY_BLK  = 8'h34;
    localparam logic [7:0] TY_DIR  = 8'h35;
    localparam logic [7:0] TY_FIFO = 8'h36;
    localparam logic [7:0] TY_LINK = 8'h4B;
    localparam logic [7:0] TY_NAME = 8'h4C;

    typedef struct {
        logic [7:0]      tb;
        longint unsigned size;
        longint unsigned mode;
        longint unsigned uid;
        longint unsigned gid;
        longint unsigned mtime;
        longint unsigned major;
        longint unsigned minor;
        bit              full;
        int              flaw;
        int              exp_type;
        longint          exp_size;
    } entry_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    in_item_t  stream_q[$];
    out_item_t expected_q[$];
    int        typed_type_q[$];
    longint    typed_size_q[$];
    logic [7:0] hdr_blk[512];
    int        errors;
    int        n_headers;
    int        n_data;
    int        n_end;
    int        n_err;
    bit        quiet;

    // Predictor state.
    logic [8:0]  blk_pos;
    phase_t      phase;
    logic [31:0] remaining;
    logic [16:0] sum_acc;
    logic [17:0] csum_val;
    logic [31:0] size_v;
    logic [23:0] mode_v;
    logic [23:0] uid_v;
    logic [23:0] gid_v;
    logic [31:0] mtime_v;
    logic [23:0] major_v;
    logic [23:0] minor_v;
    logic        fld_done;
    logic [2:0]  fault;
    logic [7:0]  tbyte;
    logic        zero_first;

    entry_row_t dir_tab[] = '{
        '{TY_NUL,  0,   12'o644, 0, 0, 0, 0, 0, 0, FL_NONE, ET_REG, 0},
        '{TY_REG,  1,   12'o755, 1000, 100, 12345, 0, 0, 0, FL_NONE, ET_REG, 1},
        '{TY_REG,  512, 0, 0, 0, 0, 0, 0, 0, FL_NONE, ET_REG, 512},
        '{TY_REG,  513, 12'o7777, 7, 7, 0, 0, 0, 0, FL_NONE, ET_REG, 513},
        '{TY_DIR,  64'hFFFFFFFFF, 64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFFFFF,
          64'hFFFFFF, 64'hFFFFFF, 1, FL_NONE, ET_DIR, 32'hFFFFFFFF},
        '{TY_SYM,  0,   12'o777, 1, 1, 99, 0, 0, 0, FL_NONE, ET_SYM, 0},
        '{TY_HARD, 0,   12'o600, 2, 3, 4, 0, 0, 0, FL_NONE, ET_HARD, 0},
        '{TY_CHR,  0,   12'o666, 0, 0, 0, 8'o377, 8'o377, 0, FL_NONE, ET_CHR, 0},
        '{TY_BLK,  0,   12'o660, 0, 6, 1, 24'o1234567, 24'o7654321, 0, FL_NONE, ET_BLK, 0},
        '{TY_FIFO, 0,   12'o644, 5, 5, 5, 1, 2, 0, FL_NONE, ET_FIFO, 0},
        '{TY_LINK, 600, 0, 0, 0, 0, 0, 0, 0, FL_OTHER_DIGIT, -1, 0},
        '{TY_NAME, 0,   0, 0, 0, 0, 0, 0, 0, FL_NONE, -1, 0},
        '{TY_NUL,  2,   12'o644, 0, 0, 0, 0, 0, 0, FL_NONE, ET_REG, 2}
    };

    tar_stream_header_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [31:0] octal_step(input logic [31:0] acc, input logic [7:0] b,
                                              input logic [2:0] fbit);
        if (fld_done)
            return acc;
        if (b >= 8'h30 && b <= 8'h37)
            return (acc << 3) + 32'(b - 8'h30);
        if (b != 8'h00 && b != 8'h20)
            fault |= fbit;
        fld_done = 1'b1;
        return acc;
    endfunction

    function automatic out_item_t parse_error(input logic [2:0] code);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code = code;
        phase = PH_ERROR;
        return r;
    endfunction

    task automatic tar_predict(input in_item_t it, output bit got, output out_item_t r);
        logic [8:0] p;
        logic [7:0] b;
        p = blk_pos;
        b = it.stream_byte;
        got = 1'b0;
        r = '0;
        if (!(phase inside {PH_HEADER, PH_DATA, PH_SKIP}))
            return;
        if (it.stream_end) begin
            r = parse_error(ERR_EARLY);
            got = 1'b1;
            return;
        end
        blk_pos = p + 9'd1;
        if (phase == PH_HEADER) begin
            if (p == 9'd0) begin
                sum_acc = '0; csum_val = '0; size_v = '0; mode_v = '0; uid_v = '0;
                gid_v = '0; mtime_v = '0; major_v = '0; minor_v = '0; fault = '0;
                tbyte = '0;
                zero_first = (b == 8'h00);
            end
            sum_acc = sum_acc + ((p >= 148 && p <= 155) ? 17'h20 : 17'(b));
            if (p inside {9'd100, 9'd108, 9'd116, 9'd124, 9'd136, 9'd148, 9'd329, 9'd337})
                fld_done = 1'b0;
            if (p >= 100 && p <= 107) mode_v = 24'(octal_step(32'(mode_v), b, FAULT_OTHER));
            else if (p >= 108 && p <= 115)
                uid_v = 24'(octal_step(32'(uid_v), b, FAULT_OTHER));
            else if (p >= 116 && p <= 123)
                gid_v = 24'(octal_step(32'(gid_v), b, FAULT_OTHER));
            else if (p >= 124 && p <= 135) size_v = octal_step(size_v, b, FAULT_SIZE);
            else if (p >= 136 && p <= 147) mtime_v = octal_step(mtime_v, b, FAULT_OTHER);
            else if (p >= 148 && p <= 153)
                csum_val = 18'(octal_step(32'(csum_val), b, FAULT_CSUM));
            else if (p == 156) tbyte = b;
            else if (p >= 329 && p <= 336)
                major_v = 24'(octal_step(32'(major_v), b, FAULT_OTHER));
            else if (p >= 337 && p <= 344)
                minor_v = 24'(octal_step(32'(minor_v), b, FAULT_OTHER));
            if (p != BLK_LAST)
                return;
            got = 1'b1;
            if (zero_first) begin
                r.result_kind = KIND_END;
                phase = PH_DONE;
            end else if (fault & FAULT_CSUM) begin
                r = parse_error(ERR_OCTAL);
            end else if (18'(sum_acc) != csum_val) begin
                r = parse_error(ERR_CSUM);
            end else if (fault & FAULT_SIZE) begin
                r = parse_error(ERR_OCTAL);
            end else if (tbyte == TY_LINK || tbyte == TY_NAME) begin
                got = 1'b0;
                remaining = size_v;
                phase = (size_v != 0) ? PH_SKIP : PH_HEADER;
            end else if (fault & FAULT_OTHER) begin
                r = parse_error(ERR_OCTAL);
            end else begin
                case (tbyte)
                    TY_NUL, TY_REG: r.entry_type = ET_REG;
                    TY_DIR:         r.entry_type = ET_DIR;
                    TY_SYM:         r.entry_type = ET_SYM;
                    TY_HARD:        r.entry_type = ET_HARD;
                    TY_CHR:         r.entry_type = ET_CHR;
                    TY_BLK:         r.entry_type = ET_BLK;
                    TY_FIFO:        r.entry_type = ET_FIFO;
                    default:        r = parse_error(ERR_TYPE);
                endcase
                if (phase != PH_ERROR) begin
                    r.result_kind = KIND_HEADER;
                    r.file_size = size_v;
                    r.file_mode = mode_v[11:0];
                    r.owner_id = uid_v;
                    r.group_id = gid_v;
                    r.modify_time = mtime_v;
                    r.device_number = {major_v[7:0], minor_v[7:0]};
                    if (r.entry_type == ET_REG && size_v != 0) begin
                        remaining = size_v;
                        phase = PH_DATA;
                    end else begin
                        phase = PH_HEADER;
                    end
                end
            end
        end else if (phase == PH_DATA) begin
            remaining = remaining - 32'd1;
            r.result_kind = KIND_DATA;
            r.data_out = b;
            r.data_last = (remaining == 0);
            if (remaining == 0)
                phase = (p == BLK_LAST) ? PH_HEADER : PH_SKIP;
            got = 1'b1;
        end else begin
            if (remaining != 0)
                remaining = remaining - 32'd1;
            if (p == BLK_LAST && remaining == 0)
                phase = PH_HEADER;
        end
    endtask

    task automatic cmp_field(input string nm, input longint unsigned g,
                             input longint unsigned e);
        if (g != e)
            report_mismatch($sformatf("%s got %0h expected %0h", nm, g, e));
    endtask

    task automatic check_result(input out_item_t g);
        out_item_t e;
        if (expected_q.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
            return;
        end
        e = expected_q.pop_front();
        cmp_field("result_kind", g.result_kind, e.result_kind);
        cmp_field("entry_type", g.entry_type, e.entry_type);
        cmp_field("file_size", g.file_size, e.file_size);
        cmp_field("file_mode", g.file_mode, e.file_mode);
        cmp_field("owner_id", g.owner_id, e.owner_id);
        cmp_field("group_id", g.group_id, e.group_id);
        cmp_field("modify_time", g.modify_time, e.modify_time);
        cmp_field("device_number", g.device_number, e.device_number);
        cmp_field("data_out", g.data_out, e.data_out);
        cmp_field("data_last", g.data_last, e.data_last);
        cmp_field("error_code", g.error_code, e.error_code);
        case (g.result_kind)
            KIND_HEADER: n_headers++;
            KIND_DATA:   n_data++;
            KIND_END:    n_end++;
            default:     n_err++;
        endcase
    endtask

    always @(posedge clk) begin
        bit        got;
        out_item_t r;
        int        t;
        longint    s;
        if (rst_n && push && !full) begin
            tar_predict(in_item, got, r);
            if (got) begin
                if (r.result_kind == KIND_HEADER && typed_type_q.size() > 0) begin
                    t = typed_type_q.pop_front();
                    s = typed_size_q.pop_front();
                    if (t != r.entry_type || s != r.file_size)
                        report_mismatch($sformatf("table row type %0d size %0h disagrees",
                                                  t, s));
                end
                expected_q.push_back(r);
            end
        end
        if (rst_n && pop && !empty)
            check_result(out_item);
    end

    task automatic put_octal(input int off, input int w, input longint unsigned v,
                             input bit whole);
        int nd;
        longint unsigned t;
        nd = 1;
        t = v >> 3;
        while (t != 0 && nd < w) begin
            nd++;
            t = t >> 3;
        end
        if (whole)
            nd = w;
        else
            nd = nd + $urandom_range(0, w - nd);
        for (int i = 0; i < nd; i++)
            hdr_blk[off + i] = 8'h30 + 8'((v >> (3 * (nd - 1 - i))) & 7);
        if (nd < w)
            hdr_blk[off + nd] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
    endtask

    task automatic add_entry(input entry_row_t e, input int cut);
        logic [7:0] bytes_q[$];
        int sum;
        longint unsigned nblk;
        in_item_t it;
        for (int i = 0; i < 512; i++)
            hdr_blk[i] = $urandom_range(0, 255);
        hdr_blk[0] = $urandom_range(1, 255);
        put_octal(100, 8, e.mode, e.full);
        put_octal(108, 8, e.uid, e.full);
        put_octal(116, 8, e.gid, e.full);
        put_octal(124, 12, e.size, e.full);
        put_octal(136, 12, e.mtime, e.full);
        put_octal(329, 8, e.major, e.full);
        put_octal(337, 8, e.minor, e.full);
        hdr_blk[156] = e.tb;
        if (e.flaw == FL_SIZE_DIGIT)
            hdr_blk[124] = $urandom_range(0, 1) ? 8'h38 : 8'hFF;
        if (e.flaw == FL_OTHER_DIGIT)
            hdr_blk[100 + 8 * $urandom_range(0, 1)] = $urandom_range(0, 1) ? 8'h39 : 8'h2F;
        for (int i = 148; i < 156; i++)
            hdr_blk[i] = 8'h20;
        sum = 0;
        for (int i = 0; i < 512; i++)
            sum += hdr_blk[i];
        if (e.flaw == FL_CSUM_WRONG)
            sum += $urandom_range(1, 7);
        for (int i = 0; i < 6; i++)
            hdr_blk[148 + i] = 8'h30 + 8'((sum >> (3 * (5 - i))) & 7);
        hdr_blk[154] = 8'h00;
        if (e.flaw == FL_CSUM_DIGIT)
            hdr_blk[148 + $urandom_range(0, 5)] = 8'h38;
        for (int i = 0; i < 512; i++)
            bytes_q.push_back(hdr_blk[i]);
        nblk = 0;
        if (e.flaw == FL_NONE && e.tb inside {TY_NUL, TY_REG})
            nblk = (e.size + 511) / 512;
        if (e.flaw inside {FL_NONE, FL_OTHER_DIGIT} && e.tb inside {TY_LINK, TY_NAME})
            nblk = (e.size + 511) / 512;
        repeat (int'(nblk) * 512)
            bytes_q.push_back($urandom_range(0, 255));
        for (int i = 0; i < bytes_q.size(); i++) begin
            if (i == cut) begin
                it.stream_byte = $urandom_range(0, 255);
                it.stream_end = 1'b1;
                stream_q.push_back(it);
                return;
            end
            it.stream_byte = bytes_q[i];
            it.stream_end = 1'b0;
            stream_q.push_back(it);
        end
    endtask

    function automatic longint unsigned rnd_field(input int bits);
        longint unsigned m;
        m = (64'd1 << bits) - 1;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(0, 511);
            2: return {$urandom, $urandom} & m;
            default: return m;
        endcase
    endfunction

    function automatic entry_row_t rnd_entry(input logic [7:0] tb);
        entry_row_t e;
        e.tb = tb;
        e.mode = rnd_field(24);
        e.uid = rnd_field(24);
        e.gid = rnd_field(24);
        e.mtime = rnd_field(36);
        e.major = rnd_field(24);
        e.minor = rnd_field(24);
        e.full = ($urandom_range(0, 9) == 0);
        e.flaw = FL_NONE;
        e.exp_type = -1;
        e.exp_size = 0;
        if (tb inside {TY_NUL, TY_REG}) begin
            e.full = 1'b0;
            if ($urandom_range(0, 3) == 0)
                e.size = 0;
            else if ($urandom_range(0, 9) == 0)
                e.size = $urandom_range(0, 2000);
            else
                e.size = $urandom_range(1, 600);
        end else if (tb inside {TY_LINK, TY_NAME}) begin
            e.full = 1'b0;
            e.size = $urandom_range(0, 1100);
            e.flaw = $urandom_range(0, 3) == 0 ? FL_OTHER_DIGIT : FL_NONE;
        end else begin
            e.size = rnd_field(36);
        end
        return e;
    endfunction

    task automatic build_stream();
        entry_row_t e;
        logic [7:0] tb;
        int start;
        int sel;
        logic [7:0] kinds[10];
        in_item_t it;
        kinds = '{TY_NUL, TY_REG, TY_DIR, TY_SYM, TY_HARD, TY_CHR, TY_BLK, TY_FIFO,
                  TY_LINK, TY_NAME};
        start = stream_q.size();
        while (stream_q.size() - start < 1100) begin
            sel = $urandom_range(0, 19);
            tb = (sel < 10) ? kinds[sel % 2] : kinds[sel - 10];
            add_entry(rnd_entry(tb), -1);
        end
        // The run closes with exactly one terminal event, since reset is never repeated.
        case ($urandom_range(0, 8))
            0: begin
                it.stream_end = 1'b0;
                for (int i = 0; i < 512; i++) begin
                    it.stream_byte = (i == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                    stream_q.push_back(it);
                end
            end
            1: add_entry(rnd_entry(TY_REG), $urandom_range(0, 511));
            2: begin
                e = rnd_entry(TY_REG);
                e.size = $urandom_range(1, 700);
                add_entry(e, 512 + $urandom_range(0, int'(e.size) - 1));
            end
            3: begin
                e = rnd_entry(TY_LINK);
                e.size = 600;
                e.flaw = FL_NONE;
                add_entry(e, 512 + $urandom_range(0, 1023));
            end
            4: begin
                e = rnd_entry(kinds[$urandom_range(0, 9)]);
                e.flaw = FL_CSUM_DIGIT;
                add_entry(e, -1);
            end
            5: begin
                e = rnd_entry(kinds[$urandom_range(0, 9)]);
                e.flaw = FL_CSUM_WRONG;
                add_entry(e, -1);
            end
            6: begin
                e = rnd_entry(kinds[$urandom_range(0, 9)]);
                e.flaw = FL_SIZE_DIGIT;
                add_entry(e, -1);
            end
            7: begin
                e = rnd_entry(kinds[$urandom_range(0, 7)]);
                e.flaw = FL_OTHER_DIGIT;
                add_entry(e, -1);
            end
            default: begin
                tb = $urandom_range(0, 255);
                while (tb inside {TY_NUL, [TY_REG:TY_FIFO], TY_LINK, TY_NAME})
                    tb = $urandom_range(0, 255);
                add_entry(rnd_entry(tb), -1);
            end
        endcase
        repeat (24) begin
            it.stream_byte = $urandom_range(0, 255);
            it.stream_end = $urandom_range(0, 1);
            stream_q.push_back(it);
        end
    endtask

    task automatic send_item(input in_item_t it);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    initial begin
        int hold;
        pop = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                hold = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int dir_len;
        int guard;
        errors = 0; n_headers = 0; n_data = 0; n_end = 0; n_err = 0;
        quiet = 1'b0;
        blk_pos = '0; phase = PH_HEADER; remaining = '0; sum_acc = '0; csum_val = '0;
        size_v = '0; mode_v = '0; uid_v = '0; gid_v = '0; mtime_v = '0; major_v = '0;
        minor_v = '0; fld_done = 1'b0; fault = '0; tbyte = '0; zero_first = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        foreach (dir_tab[i]) begin
            add_entry(dir_tab[i], -1);
            if (dir_tab[i].exp_type >= 0) begin
                typed_type_q.push_back(dir_tab[i].exp_type);
                typed_size_q.push_back(dir_tab[i].exp_size);
            end
        end
        dir_len = stream_q.size();
        build_stream();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stream_q[i]) begin
            if (i == dir_len) begin
                push <= 1'b0;
                @(posedge clk);
                while (expected_q.size() != 0)
                    @(posedge clk);
            end
            if (i + 200 > stream_q.size())
                quiet = 1'b1;
            send_item(stream_q[i]);
        end
        push <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        $display("Streamed %0d bytes: %0d headers, %0d data bytes, %0d end, %0d error results.",
                 stream_q.size(), n_headers, n_data, n_end, n_err);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
